// File: sv/bpr_pkg.sv
// shared types and constants for the buffer pool replacement unit
package bpr_pkg;

    localparam int MAX_SLOTS_DEF = 16;
    localparam int PIN_BITS_DEF  = 8;

    localparam logic [1:0] MODE_LRU    = 2'd0;
    localparam logic [1:0] MODE_MRU    = 2'd1;
    localparam logic [1:0] MODE_CYCLIC = 2'd2;

    localparam logic REQ_GET     = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SLOT    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
    localparam logic [1:0] ST_NOT_PINNED = 2'd3;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_SLOTS = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  relation;
        logic [15:0] page_number;
    } bpr_in_t;

    typedef struct packed {
        logic [3:0]  slot_index;
        logic        was_hit;
        logic        needs_read;
        logic [1:0]  status;
        logic [7:0]  pin_after;
        logic [31:0] request_total;
        logic [31:0] release_total;
        logic [31:0] hit_total;
        logic [31:0] read_total;
    } bpr_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_CYC_MOD,
        S_CYC_SCAN,
        S_LIST_FIND,
        S_LIST_SHIFT,
        S_FINISH
    } bpr_state_t;

endpackage

// File: sv/bpr_core.sv
// sequencer with one shared compare/walk unit over slot tags, pins and the unpinned list
module bpr_core
    import bpr_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int PIN_BITS  = PIN_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  bpr_in_t    item,
    input  logic [1:0] mode,
    input  logic [4:0] slots_cfg,
    output logic       busy,
    output logic       done,
    output bpr_out_t   result,
    input  logic       result_taken
);
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    logic [MAX_SLOTS-1:0] valid_reg;
    logic [7:0]           rel_mem  [MAX_SLOTS];
    logic [15:0]          page_mem [MAX_SLOTS];
    logic [PIN_BITS-1:0]  pins_reg [MAX_SLOTS];
    logic [IW-1:0]        order_mem[MAX_SLOTS];
    logic [CW-1:0]        fresh_reg, ucount_reg;
    logic [IW-1:0]        cptr_reg;
    logic [IW-1:0]        cbase_reg;
    logic [31:0]          req_cnt_reg, rel_cnt_reg, hit_cnt_reg, rd_cnt_reg;

    bpr_state_t state_reg, state_next;
    bpr_in_t    item_reg;
    logic [CW-1:0] n_reg, idx_reg;
    logic [IW-1:0] slot_reg;
    logic          found_reg, hit_reg, rd_reg;
    logic [1:0]    status_reg;
    logic [PIN_BITS-1:0] pin_next;
    bpr_out_t      result_reg;
    logic          out_valid_reg;
    logic          out_free;

    assign out_free = !out_valid_reg || result_taken;

    // active slot count from config
    logic [CW-1:0] n_act;
    always_comb begin
        if (slots_cfg == 5'd0) n_act = CW'(1);
        else if (32'(slots_cfg) > MAX_SLOTS) n_act = CW'(MAX_SLOTS);
        else n_act = CW'(slots_cfg);
    end

    logic [IW-1:0] idx_s;
    assign idx_s = idx_reg[IW-1:0];
    logic tag_match;
    assign tag_match = valid_reg[idx_s] && rel_mem[idx_s] == item_reg.relation
                       && page_mem[idx_s] == item_reg.page_number;
    // cyclic scan slot: folded pointer + step modulo n (both below n)
    logic [CW:0]   csum;
    logic [IW-1:0] cslot;
    always_comb begin
        csum = (CW+1)'(cbase_reg) + (CW+1)'(idx_reg);
        if (csum >= (CW+1)'(n_reg)) csum = csum - (CW+1)'(n_reg);
        cslot = csum[IW-1:0];
    end
    logic [CW:0] cnext;
    assign cnext = (CW+1)'(cslot) + 1'b1 >= (CW+1)'(n_reg) ? '0 : (CW+1)'(cslot) + 1'b1;
    logic is_lru_mru;
    assign is_lru_mru = (mode == MODE_LRU) || (mode == MODE_MRU);

    // pin count written back at finish
    always_comb begin
        if (item_reg.req_type == REQ_GET) begin
            if (rd_reg) pin_next = PIN_BITS'(1);
            else if (pins_reg[slot_reg] < PIN_MAX) pin_next = pins_reg[slot_reg] + 1'b1;
            else pin_next = PIN_MAX;
        end else begin
            pin_next = pins_reg[slot_reg] - 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (start) state_next = S_SEARCH;
            S_SEARCH:    if (tag_match || idx_reg + 1'b1 >= n_reg) state_next = S_DECIDE;
            S_DECIDE: begin
                if (item_reg.req_type == REQ_RELEASE || found_reg || fresh_reg < n_reg
                    || !is_lru_mru) begin
                    if (item_reg.req_type == REQ_GET && !found_reg && fresh_reg >= n_reg)
                        state_next = S_CYC_MOD;
                    else state_next = (item_reg.req_type == REQ_GET) ? S_LIST_FIND : S_FINISH;
                end else begin
                    state_next = (ucount_reg == '0) ? S_FINISH :
                                 (mode == MODE_LRU) ? S_LIST_SHIFT : S_FINISH;
                end
            end
            S_CYC_MOD:   if (CW'(cbase_reg) < n_reg) state_next = S_CYC_SCAN;
            S_CYC_SCAN: if (pins_reg[cslot] == '0 || idx_reg + 1'b1 >= n_reg)
                            state_next = (pins_reg[cslot] == '0) ? S_LIST_FIND : S_FINISH;
            S_LIST_FIND: begin
                if (idx_reg >= ucount_reg) state_next = S_FINISH;
                else if (order_mem[idx_s] == slot_reg) state_next = S_LIST_SHIFT;
            end
            S_LIST_SHIFT: if (idx_reg + 1'b1 >= ucount_reg) state_next = S_FINISH;
            S_FINISH:    if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = out_valid_reg;
    assign result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            for (int i = 0; i < MAX_SLOTS; i++) pins_reg[i] <= '0;
            fresh_reg   <= '0;
            ucount_reg  <= '0;
            cptr_reg    <= '0;
            req_cnt_reg <= '0;
            rel_cnt_reg <= '0;
            hit_cnt_reg <= '0;
            rd_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_FINISH && out_free) out_valid_reg <= 1'b1;
            else if (result_taken) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (start) begin
                    item_reg   <= item;
                    n_reg      <= n_act;
                    idx_reg    <= '0;
                    found_reg  <= 1'b0;
                    hit_reg    <= 1'b0;
                    rd_reg     <= 1'b0;
                    status_reg <= ST_OK;
                    slot_reg   <= '0;
                    if (item.req_type == REQ_GET) req_cnt_reg <= req_cnt_reg + 1'b1;
                    else rel_cnt_reg <= rel_cnt_reg + 1'b1;
                end
                S_SEARCH: begin
                    if (tag_match) begin
                        found_reg <= 1'b1;
                        slot_reg  <= idx_s;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                S_DECIDE: begin
                    idx_reg   <= '0;
                    cbase_reg <= cptr_reg;
                    if (item_reg.req_type == REQ_RELEASE) begin
                        if (!found_reg) status_reg <= ST_NOT_FOUND;
                        else if (pins_reg[slot_reg] == '0) status_reg <= ST_NOT_PINNED;
                    end else if (found_reg) begin
                        hit_reg     <= 1'b1;
                        hit_cnt_reg <= hit_cnt_reg + 1'b1;
                    end else if (fresh_reg < n_reg) begin
                        slot_reg  <= fresh_reg[IW-1:0];
                        fresh_reg <= fresh_reg + 1'b1;
                        rd_reg    <= 1'b1;
                    end else if (is_lru_mru) begin
                        if (ucount_reg == '0) status_reg <= ST_NO_SLOT;
                        else begin
                            rd_reg <= 1'b1;
                            if (mode == MODE_LRU) slot_reg <= order_mem[0];
                            else slot_reg <= order_mem[ucount_reg[IW-1:0] - 1'b1];
                            if (mode == MODE_MRU) ucount_reg <= ucount_reg - 1'b1;
                        end
                    end
                end
                S_CYC_MOD: begin
                    // pointer may be left over from a larger slot count
                    if (CW'(cbase_reg) >= n_reg) cbase_reg <= cbase_reg - n_reg[IW-1:0];
                end
                S_CYC_SCAN: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (pins_reg[cslot] == '0) begin
                        slot_reg <= cslot;
                        rd_reg   <= 1'b1;
                        cptr_reg <= cnext[IW-1:0];
                        idx_reg  <= '0;
                    end else if (idx_reg + 1'b1 >= n_reg) status_reg <= ST_NO_SLOT;
                end
                S_LIST_FIND: begin
                    if (idx_reg < ucount_reg && order_mem[idx_s] != slot_reg)
                        idx_reg <= idx_reg + 1'b1;
                end
                S_LIST_SHIFT: begin
                    // close the gap one entry per cycle
                    if (idx_reg + 1'b1 < ucount_reg)
                        order_mem[idx_s] <= order_mem[idx_s + 1'b1];
                    else ucount_reg <= ucount_reg - 1'b1;
                    idx_reg <= idx_reg + 1'b1;
                end
                S_FINISH: if (out_free) begin
                    result_reg.was_hit    <= hit_reg;
                    result_reg.needs_read <= rd_reg;
                    result_reg.status     <= status_reg;
                    result_reg.slot_index <= '0;
                    result_reg.pin_after  <= '0;
                    result_reg.hit_total  <= hit_cnt_reg;
                    result_reg.request_total <= req_cnt_reg;
                    result_reg.release_total <= rel_cnt_reg;
                    result_reg.read_total <= rd_reg ? rd_cnt_reg + 1'b1 : rd_cnt_reg;
                    if (rd_reg) begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                        valid_reg[slot_reg] <= 1'b1;
                        rel_mem[slot_reg]   <= item_reg.relation;
                        page_mem[slot_reg]  <= item_reg.page_number;
                        pins_reg[slot_reg]  <= PIN_BITS'(1);
                    end
                    if (status_reg == ST_OK) begin
                        result_reg.slot_index <= 4'(32'(slot_reg));
                        if (item_reg.req_type == REQ_RELEASE) begin
                            if (pins_reg[slot_reg] == PIN_BITS'(1)
                                && 32'(ucount_reg) < MAX_SLOTS) begin
                                order_mem[ucount_reg[IW-1:0]] <= slot_reg;
                                ucount_reg <= ucount_reg + 1'b1;
                            end
                        end
                        pins_reg[slot_reg]   <= pin_next;
                        result_reg.pin_after <= 8'(32'(pin_next));
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// File: sv/buffer_pool_replacement_unit.sv
// top level of the buffer pool replacement unit
// sequence: tag search, decide, cyclic pointer fold and cyclic scan when needed, list find
// and shift of the unpinned list, then finish, which loads the result register
// throughput: one item in flight; next input taken the cycle after its result is loaded
// a waiting result sits in the output register and stalls only the next item's finish
// synchronous active-low reset clears valid bits, pins, pointers, counters; config lru, 16
module buffer_pool_replacement_unit
    import bpr_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int PIN_BITS  = PIN_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bpr_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output bpr_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [1:0] mode_reg;
    logic [4:0] slots_reg;
    logic       busy;

    // config writes always taken; the user must write them only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_LRU;
            slots_reg <= 5'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[1:0];
                CFG_SLOTS: slots_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // ready only while the sequencer is idle
    assign s_ready = !busy;

    bpr_core #(.MAX_SLOTS(MAX_SLOTS), .PIN_BITS(PIN_BITS)) u_core (
        .aclk(aclk), .aresetn(aresetn),
        .start(s_valid && s_ready), .item(s_data),
        .mode(mode_reg), .slots_cfg(slots_reg),
        .busy(busy), .done(m_valid), .result(m_data),
        .result_taken(m_ready)
    );
endmodule

// File: sv/bpr_checker.sv
// port-level checker for the buffer pool replacement unit
module bpr_checker
    import bpr_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input bpr_out_t m_data
);
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("second input taken while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !$isunknown(m_data)) else $error("unknown bits in result");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.slot_index == '0
        && m_data.pin_after == '0) else $error("error result not zeroed");
    a_hit_noread: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.was_hit && m_data.needs_read)) else $error("hit and read");
endmodule

bind buffer_pool_replacement_unit bpr_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
